@@ hw/rtl/psb_pkg.sv @@
// Shared types and constants for the priority slot buffer.
// No dependencies; every other file but psb_ram imports this package.
package psb_pkg;

	localparam int DEPTH    = 16;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int CFG_W    = 5;
	localparam int SRC_W    = 8;
	localparam int TAG_W    = 16;
	localparam int SLOT_W   = 4;
	localparam int FREE_W   = 5;
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int DATA_W   = SRC_W + TAG_W;
	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_TAKE   = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		RES_INS_FREE   = 2'd0,
		RES_INS_EVICT  = 2'd1,
		RES_TAKEN      = 2'd2,
		RES_TAKE_EMPTY = 2'd3
	} res_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_SCAN,
		ST_EVICT_RD,
		ST_EVICT_WR,
		ST_TAKE_SCAN,
		ST_TAKE_LAST,
		ST_TAKE_FIN
	} state_t;

	typedef struct packed {
		op_t              op;
		logic [SRC_W-1:0] src;
		logic [TAG_W-1:0] tag;
	} item_t;

	typedef struct packed {
		res_status_t       status;
		logic [SLOT_W-1:0] slot;
		logic [SRC_W-1:0]  src;
		logic [TAG_W-1:0]  tag;
		logic [FREE_W-1:0] free;
	} result_t;

	// Effective slot count: zero acts as one, anything above DEPTH as DEPTH.
	function automatic logic [CNT_W-1:0] used_slots(input logic [CFG_W-1:0] cfg);
		int v;
		v = int'(cfg);
		if (v == 0) begin
			v = 1;
		end else if (v > DEPTH) begin
			v = DEPTH;
		end
		return CNT_W'(v);
	endfunction

endpackage

@@ hw/rtl/psb_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module psb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     write_en,
	input  logic [$clog2(DEPTH)-1:0] write_addr,
	input  logic [WIDTH-1:0]         write_data,
	input  logic [$clog2(DEPTH)-1:0] read_addr,
	output logic [WIDTH-1:0]         read_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (write_en) begin
			mem_q[write_addr] <= write_data;
		end
		read_data <= mem_q[read_addr];
	end

endmodule

@@ hw/rtl/psb_front.sv @@
// Front end: accepts beats, classifies them into insert/take items and
// queues them for the back end. Depends on psb_pkg.
module psb_front import psb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic             mode,
	input  logic [SRC_W-1:0] source_number,
	input  logic [TAG_W-1:0] request_tag,
	input  logic             deq,
	output logic             item_valid,
	output item_t            item
);

	item_t             queue_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              enq;
	logic              take_out;
	item_t             item_in;

	assign full       = (count_q == (QPTR_W + 1)'(QDEPTH));
	assign item_valid = (count_q != '0);
	assign item       = queue_q[rd_ptr_q];
	assign enq        = push && !full;
	assign take_out   = deq && item_valid;

	always_comb begin
		item_in.op  = op_t'(mode);
		item_in.src = source_number;
		item_in.tag = request_tag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (take_out) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (enq && !take_out) begin
				count_q <= count_q + (QPTR_W + 1)'(1);
			end else if (!enq && take_out) begin
				count_q <= count_q - (QPTR_W + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (enq) begin
			queue_q[wr_ptr_q] <= item_in;
		end
	end

endmodule

@@ hw/rtl/psb_back.sv @@
// Back end: slot bookkeeping, one-slot-per-cycle scans and the result register.
// Depends on psb_pkg and psb_ram.
module psb_back import psb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             item_valid,
	input  item_t            item,
	output logic             deq,
	output logic             res_valid,
	output result_t          res,
	input  logic             pop
);

	state_t            state_q, state_d;
	logic [CFG_W-1:0]  cfg_q;
	logic [DEPTH-1:0]  valid_q;
	logic [IDX_W-1:0]  ptr_q;
	logic [CNT_W-1:0]  free_q;
	logic [IDX_W-1:0]  scan_q;
	item_t             item_q;
	logic              found_q;
	logic              pend_q;
	logic [IDX_W-1:0]  pend_idx_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [SRC_W-1:0]  best_src_q;
	logic [TAG_W-1:0]  best_tag_q;
	logic              out_valid_q;
	result_t           out_q;

	logic [CNT_W-1:0]  n;
	logic [IDX_W-1:0]  ptr_fix;
	logic [IDX_W-1:0]  ptr_prev;
	logic              scan_wrap;
	logic [IDX_W-1:0]  scan_next;
	logic              start;
	logic              upd;
	logic              ram_we;
	logic [DATA_W-1:0] ram_wdata;
	logic [DATA_W-1:0] ram_rdata;
	logic [SRC_W-1:0]  rd_src;
	logic [TAG_W-1:0]  rd_tag;
	logic              res_load;
	result_t           res_d;

	assign n         = used_slots(cfg_q);
	assign ptr_fix   = (CNT_W'(ptr_q) >= n) ? '0 : ptr_q;
	assign ptr_prev  = (ptr_fix == '0) ? IDX_W'(n - CNT_W'(1)) : ptr_fix - IDX_W'(1);
	assign scan_wrap = (CNT_W'(scan_q) + CNT_W'(1) == n);
	assign scan_next = scan_wrap ? '0 : scan_q + IDX_W'(1);
	assign start     = (state_q == ST_IDLE) && item_valid && !out_valid_q;
	assign rd_src    = ram_rdata[DATA_W-1:TAG_W];
	assign rd_tag    = ram_rdata[TAG_W-1:0];
	// pending read compares against the running minimum; ties keep the lower slot
	assign upd       = pend_q && (!found_q || rd_src < best_src_q);
	assign ram_wdata = {item_q.src, item_q.tag};

	psb_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_slot_ram (
		.clk        (clk),
		.write_en   (ram_we),
		.write_addr (scan_q),
		.write_data (ram_wdata),
		.read_addr  (scan_q),
		.read_data  (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (item.op == OP_TAKE) begin
						state_d = (free_q == n) ? ST_IDLE : ST_TAKE_SCAN;
					end else begin
						state_d = (free_q != '0) ? ST_INS_SCAN : ST_EVICT_RD;
					end
				end
			end
			ST_INS_SCAN: begin
				if (!valid_q[scan_q]) begin
					state_d = ST_IDLE;
				end
			end
			ST_EVICT_RD:  state_d = ST_EVICT_WR;
			ST_EVICT_WR:  state_d = ST_IDLE;
			ST_TAKE_SCAN: begin
				if (scan_wrap) begin
					state_d = ST_TAKE_LAST;
				end
			end
			ST_TAKE_LAST: state_d = ST_TAKE_FIN;
			ST_TAKE_FIN:  state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		deq          = start;
		ram_we       = 1'b0;
		res_load     = 1'b0;
		res_d        = '0;
		res_d.status = RES_TAKE_EMPTY;
		res_d.free   = FREE_W'(free_q);
		case (state_q)
			ST_IDLE: begin
				res_load = start && (item.op == OP_TAKE) && (free_q == n);
			end
			ST_INS_SCAN: begin
				if (!valid_q[scan_q]) begin
					ram_we       = 1'b1;
					res_load     = 1'b1;
					res_d.status = RES_INS_FREE;
					res_d.slot   = SLOT_W'(scan_q);
					res_d.free   = FREE_W'(free_q - CNT_W'(1));
				end
			end
			ST_EVICT_WR: begin
				ram_we       = 1'b1;
				res_load     = 1'b1;
				res_d.status = RES_INS_EVICT;
				res_d.slot   = SLOT_W'(scan_q);
				res_d.src    = rd_src;
				res_d.tag    = rd_tag;
			end
			ST_TAKE_FIN: begin
				res_load     = 1'b1;
				res_d.status = RES_TAKEN;
				res_d.slot   = SLOT_W'(best_idx_q);
				res_d.src    = best_src_q;
				res_d.tag    = best_tag_q;
				res_d.free   = FREE_W'((free_q < n) ? free_q + CNT_W'(1) : free_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cfg_q       <= CFG_RESET;
			valid_q     <= '0;
			ptr_q       <= '0;
			free_q      <= used_slots(CFG_RESET);
			found_q     <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				// resizing empties the buffer
				cfg_q   <= cfg_data;
				valid_q <= '0;
				ptr_q   <= '0;
				free_q  <= used_slots(cfg_data);
			end else begin
				case (state_q)
					ST_IDLE: begin
						if (start) begin
							ptr_q <= ptr_fix;
						end
					end
					ST_INS_SCAN: begin
						if (!valid_q[scan_q]) begin
							valid_q[scan_q] <= 1'b1;
							ptr_q           <= scan_next;
							free_q          <= free_q - CNT_W'(1);
						end
					end
					ST_EVICT_WR: begin
						valid_q[scan_q] <= 1'b1;
						ptr_q           <= scan_q;
					end
					ST_TAKE_FIN: begin
						valid_q[best_idx_q] <= 1'b0;
						if (free_q < n) begin
							free_q <= free_q + CNT_W'(1);
						end
					end
					default: begin
					end
				endcase
			end
			if (start) begin
				found_q <= 1'b0;
			end else if (upd) begin
				found_q <= 1'b1;
			end
			pend_q <= (state_q == ST_TAKE_SCAN) && valid_q[scan_q];
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			item_q <= item;
			if (item.op == OP_TAKE) begin
				scan_q <= '0;
			end else if (free_q != '0) begin
				scan_q <= ptr_fix;
			end else begin
				scan_q <= ptr_prev;
			end
		end else if (state_q == ST_TAKE_SCAN
		             || (state_q == ST_INS_SCAN && valid_q[scan_q])) begin
			scan_q <= scan_next;
		end
		pend_idx_q <= scan_q;
		if (upd) begin
			best_idx_q <= pend_idx_q;
			best_src_q <= rd_src;
			best_tag_q <= rd_tag;
		end
		if (res_load) begin
			out_q <= res_d;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

@@ hw/rtl/priority_slot_buffer_unit.sv @@
// Top level of the priority slot buffer: front queue plus slot engine.
// Depends on psb_pkg, psb_front, psb_back (and psb_ram through psb_back).
//
// Requests (source number + tag) are held in up to 16 slots; a take returns
// the lowest source number, lowest slot on a tie. Beats are pushed into a
// four-deep queue, so pushes continue while a result waits to be popped.
// The slot engine handles one item at a time, one slot per cycle over the
// single read port of the slot RAM: an insert into a free slot scans from
// the insert pointer, an insert into a full buffer reads and overwrites the
// slot just behind the pointer, a take scans every slot in use, and a take
// on an empty buffer is answered from idle. A write to cfg_data resizes and
// empties the buffer; write it only while the block is idle.
module priority_slot_buffer_unit import psb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              push,
	output logic              full,
	input  logic              mode,
	input  logic [SRC_W-1:0]  source_number,
	input  logic [TAG_W-1:0]  request_tag,
	output logic              empty,
	input  logic              pop,
	output logic [1:0]        status,
	output logic [SLOT_W-1:0] slot_index,
	output logic [SRC_W-1:0]  out_source,
	output logic [TAG_W-1:0]  out_tag,
	output logic [FREE_W-1:0] free_slots
);

	logic    item_valid;
	item_t   item;
	logic    deq;
	logic    res_valid;
	result_t res;

	psb_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.mode          (mode),
		.source_number (source_number),
		.request_tag   (request_tag),
		.deq           (deq),
		.item_valid    (item_valid),
		.item          (item)
	);

	psb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.item       (item),
		.deq        (deq),
		.res_valid  (res_valid),
		.res        (res),
		.pop        (pop)
	);

	assign empty      = !res_valid;
	assign status     = res.status;
	assign slot_index = res.slot;
	assign out_source = res.src;
	assign out_tag    = res.tag;
	assign free_slots = res.free;

endmodule

@@ bench/psb_checker.sv @@
// Scoreboard for the priority slot buffer: watches the push, pop and resize ports.
// Predicts every result from its own copy of the slots and compares it field by field.
// Depends on psb_pkg.
`timescale 1ns / 100ps

module psb_checker import psb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              push,
	input  logic              full,
	input  logic              mode,
	input  logic [SRC_W-1:0]  source_number,
	input  logic [TAG_W-1:0]  request_tag,
	input  logic              empty,
	input  logic              pop,
	input  logic [1:0]        status,
	input  logic [SLOT_W-1:0] slot_index,
	input  logic [SRC_W-1:0]  out_source,
	input  logic [TAG_W-1:0]  out_tag,
	input  logic [FREE_W-1:0] free_slots,
	output int                mismatches,
	output int                outstanding,
	output int                results_checked,
	output int                evictions,
	output int                empty_takes
);

	// shadow copy of the slot store
	logic             occupied [DEPTH];
	logic [SRC_W-1:0] held_src [DEPTH];
	logic [TAG_W-1:0] held_tag [DEPTH];
	int               ins_ptr;
	int               free_cnt;
	logic [CFG_W-1:0] size_reg;

	result_t due_results[$];

	// out-of-range sizes clamp: 0 acts as 1, above DEPTH acts as DEPTH
	function automatic int active_slots(input logic [CFG_W-1:0] v);
		if (v == '0) begin
			return 1;
		end
		if (int'(v) > DEPTH) begin
			return DEPTH;
		end
		return int'(v);
	endfunction

	function automatic void clear_slots();
		for (int i = 0; i < DEPTH; i++) begin
			occupied[i] = 1'b0;
		end
		ins_ptr  = 0;
		free_cnt = active_slots(size_reg);
	endfunction

	// applies one request to the shadow store and returns the result it causes
	function automatic result_t serve_request(input op_t op, input logic [SRC_W-1:0] s,
			input logic [TAG_W-1:0] t);
		result_t r;
		int      n;
		int      p;
		int      i;
		int      best;
		bit      hit;
		r = '0;
		n = active_slots(size_reg);
		if (ins_ptr >= n) begin
			ins_ptr = 0;
		end
		if (op == OP_INSERT) begin
			if (free_cnt != 0) begin
				p   = ins_ptr;
				hit = 1'b0;
				i   = 0;
				while (i < n && !hit) begin
					if (!occupied[p]) begin
						hit = 1'b1;
					end else begin
						p = (p + 1 == n) ? 0 : p + 1;
						i++;
					end
				end
				if (!hit) begin
					p = ins_ptr;
				end
				occupied[p] = 1'b1;
				held_src[p] = s;
				held_tag[p] = t;
				ins_ptr     = (p + 1 == n) ? 0 : p + 1;
				free_cnt--;
				r.status = RES_INS_FREE;
				r.slot   = SLOT_W'(p);
			end else begin
				// full: overwrite the newest request, just behind the pointer
				p           = (ins_ptr == 0) ? n - 1 : ins_ptr - 1;
				r.src       = held_src[p];
				r.tag       = held_tag[p];
				occupied[p] = 1'b1;
				held_src[p] = s;
				held_tag[p] = t;
				ins_ptr     = p;
				r.status    = RES_INS_EVICT;
				r.slot      = SLOT_W'(p);
			end
		end else begin
			hit  = 1'b0;
			best = 0;
			for (i = 0; i < n; i++) begin
				if (occupied[i] && (!hit || held_src[i] < held_src[best])) begin
					best = i;
					hit  = 1'b1;
				end
			end
			if (hit) begin
				r.src          = held_src[best];
				r.tag          = held_tag[best];
				r.slot         = SLOT_W'(best);
				occupied[best] = 1'b0;
				if (free_cnt < n) begin
					free_cnt++;
				end
				r.status = RES_TAKEN;
			end else begin
				r.status = RES_TAKE_EMPTY;
			end
		end
		r.free = FREE_W'(free_cnt);
		return r;
	endfunction

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			size_reg = CFG_RESET;
			clear_slots();
			due_results.delete();
			mismatches      = 0;
			results_checked = 0;
			evictions       = 0;
			empty_takes     = 0;
		end else begin
			if (pop && !empty) begin
				got.status = res_status_t'(status);
				got.slot   = slot_index;
				got.src    = out_source;
				got.tag    = out_tag;
				got.free   = free_slots;
				results_checked++;
				if (due_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: result beat with nothing expected: status %0d slot %0d",
							$realtime, status, slot_index);
					end
				end else begin
					want = due_results.pop_front();
					if (got.status != want.status || got.slot != want.slot ||
							got.src != want.src || got.tag != want.tag ||
							got.free != want.free) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: mismatch exp status %0d slot %0d src %0d tag %h free %0d",
								$realtime, want.status, want.slot, want.src, want.tag, want.free);
							$display("%0t:          got status %0d slot %0d src %0d tag %h free %0d",
								$realtime, got.status, got.slot, got.src, got.tag, got.free);
						end
					end
					if (want.status == RES_INS_EVICT) begin
						evictions++;
					end
					if (want.status == RES_TAKE_EMPTY) begin
						empty_takes++;
					end
				end
			end
			if (cfg_write) begin
				size_reg = cfg_data;
				clear_slots();
			end
			if (push && !full) begin
				due_results.push_back(serve_request(op_t'(mode), source_number, request_tag));
			end
		end
		outstanding <= due_results.size();
	end

endmodule

@@ bench/tb_priority_slot_buffer_unit.sv @@
// Testbench top for priority_slot_buffer_unit: clock, reset, stimulus and verdict.
// Depends on psb_pkg, the RTL and bench/psb_checker.sv.
`timescale 1ns / 100ps

module tb_priority_slot_buffer_unit;
	import psb_pkg::*;

	localparam int N_PHASES    = 10;
	localparam int PHASE_ITEMS = 143;
	localparam int HOLD_PHASE  = 5;
	localparam int DRAIN_PHASE = 3;
	localparam int HOLD_CYCLES = 400;
	localparam int LIMIT       = 400000;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_write;
	logic [CFG_W-1:0]  cfg_data;
	logic              push;
	logic              full;
	logic              mode;
	logic [SRC_W-1:0]  source_number;
	logic [TAG_W-1:0]  request_tag;
	logic              empty;
	logic              pop;
	logic [1:0]        status;
	logic [SLOT_W-1:0] slot_index;
	logic [SRC_W-1:0]  out_source;
	logic [TAG_W-1:0]  out_tag;
	logic [FREE_W-1:0] free_slots;

	int mismatches;
	int outstanding;
	int results_checked;
	int evictions;
	int empty_takes;

	int tx_gap_pct = 0;
	int rx_gap_pct = 0;
	bit stall_req  = 1'b0;
	int items_sent = 0;
	int n_resizes  = 0;
	int cycles     = 0;

	priority_slot_buffer_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_data      (cfg_data),
		.push          (push),
		.full          (full),
		.mode          (mode),
		.source_number (source_number),
		.request_tag   (request_tag),
		.empty         (empty),
		.pop           (pop),
		.status        (status),
		.slot_index    (slot_index),
		.out_source    (out_source),
		.out_tag       (out_tag),
		.free_slots    (free_slots)
	);

	psb_checker chk (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycles, outstanding);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// result side: random stall bursts, plus one long hold-off on request
	initial begin
		pop = 1'b0;
		forever begin
			if (stall_req) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				stall_req = 1'b0;
			end else if (rx_gap_pct != 0 && $urandom_range(0, 99) < rx_gap_pct) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				pop <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// offers one beat and returns at the edge that accepts it; push stays high
	// unless a gap follows
	task automatic put_request(input op_t op, input logic [SRC_W-1:0] s,
			input logic [TAG_W-1:0] t);
		push          <= 1'b1;
		mode          <= op;
		source_number <= s;
		request_tag   <= t;
		do @(posedge clk); while (full);
		items_sent++;
		if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic resize(input logic [CFG_W-1:0] v);
		wait_drained();
		repeat (8) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		cfg_write <= 1'b0;
		n_resizes++;
	endtask

	initial begin
		int          phase_sizes [N_PHASES];
		int          take_pct;
		int          r;
		op_t         op;
		logic [SRC_W-1:0] s;
		arst_n        = 1'b0;
		cfg_write     = 1'b0;
		cfg_data      = '0;
		push          = 1'b0;
		mode          = OP_INSERT;
		source_number = '0;
		request_tag   = '0;
		phase_sizes   = '{31, 1, 17, 0, 3, 16, 2, 8, 5, 16};
		phase_sizes[8] = $urandom_range(0, 31);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty take, extreme fields, ties, then tiny and clamped sizes
		rx_gap_pct = 10;
		put_request(OP_TAKE,   8'h00, 16'h0000);
		put_request(OP_INSERT, 8'hFF, 16'hFFFF);
		put_request(OP_INSERT, 8'h00, 16'h0000);
		put_request(OP_INSERT, 8'h00, 16'h1234);
		put_request(OP_INSERT, 8'h80, 16'hAAAA);
		repeat (5) put_request(OP_TAKE, 8'hFF, 16'hFFFF);
		resize(5'd1);
		put_request(OP_INSERT, 8'h07, 16'h5555);
		put_request(OP_INSERT, 8'h09, 16'h00FF);
		repeat (2) put_request(OP_TAKE, 8'h00, 16'h0000);
		resize(5'd0);
		put_request(OP_INSERT, 8'hC8, 16'hFFFF);
		put_request(OP_INSERT, 8'h01, 16'h0001);
		put_request(OP_TAKE,   8'h00, 16'h0000);
		resize(5'd31);
		put_request(OP_INSERT, 8'h03, 16'h3333);
		// resizing with a request still held drops it
		resize(5'd2);
		put_request(OP_INSERT, 8'hFF, 16'hFFFF);
		put_request(OP_INSERT, 8'hFF, 16'h0000);
		put_request(OP_INSERT, 8'h00, 16'hFFFF);
		repeat (3) put_request(OP_TAKE, 8'h00, 16'h0000);

		for (int ph = 0; ph < N_PHASES; ph++) begin
			r = $urandom_range(0, 2);
			tx_gap_pct = (r == 0) ? 0 : (r == 1) ? 8 : 20;
			r = $urandom_range(0, 2);
			rx_gap_pct = (r == 0) ? 0 : (r == 1) ? 8 : 20;
			if (ph == N_PHASES - 1) begin
				tx_gap_pct = 0;
				rx_gap_pct = 0;
			end
			r = $urandom_range(0, 2);
			take_pct = (r == 0) ? 25 : (r == 1) ? 45 : 65;
			resize(CFG_W'(phase_sizes[ph]));
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (ph == HOLD_PHASE && k == 10) begin
					stall_req = 1'b1;
				end
				if (ph == DRAIN_PHASE && k == PHASE_ITEMS / 2) begin
					wait_drained();
				end
				op = ($urandom_range(0, 99) < take_pct) ? OP_TAKE : OP_INSERT;
				// narrow source range forces ties on the minimum search
				r = $urandom_range(0, 99);
				if (r < 35) begin
					s = SRC_W'($urandom_range(0, 3));
				end else if (r < 40) begin
					s = r[0] ? 8'hFF : 8'h00;
				end else begin
					s = SRC_W'($urandom);
				end
				put_request(op, s, TAG_W'($urandom));
			end
		end

		wait_drained();
		repeat (40) @(posedge clk);
		$display("Ran %0d requests over %0d buffer sizes; %0d results checked.",
			items_sent, n_resizes + 1, results_checked);
		$display("Saw %0d evictions and %0d takes from an empty buffer.",
			evictions, empty_takes);
		if (mismatches == 0 && outstanding == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/psb_pkg.sv
hw/rtl/psb_ram.sv
hw/rtl/psb_front.sv
hw/rtl/psb_back.sv
hw/rtl/priority_slot_buffer_unit.sv
bench/psb_checker.sv
bench/tb_priority_slot_buffer_unit.sv
